// File: sv/vln_pkg.sv
`default_nettype none

package vln_pkg;

  localparam int ELEM_BITS   = 24;
  localparam int FRAC_OUT    = 22;
  localparam int UNIT_W      = 24;
  localparam int NORM_W      = 27;
  localparam int STAT_W      = 2;
  localparam int MAX_LEN_DEF = 64;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TRUNC = 2'd2;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] element;
    logic                        last;
  } in_item_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_value;
    logic [NORM_W-1:0]        norm;
    logic [STAT_W-1:0]        status;
    logic                     end_of_vector;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQRT,
    S_FETCH,
    S_LOAD,
    S_DIV,
    S_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// File: sv/vln_store.sv
`default_nettype none

module vln_store #(
  parameter int AW = 7,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [0:(2**AW)-1];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: sv/vln_queue.sv
`default_nettype none

module vln_queue #(
  parameter int CNT_W = 7,
  parameter int SUM_W = 53
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [CNT_W-1:0] push_cnt,
  input  wire logic [SUM_W-1:0] push_sum,
  input  wire logic             push_ovf,
  input  wire logic             pop,
  output logic      [1:0]       count,
  output logic                  head_valid,
  output logic      [CNT_W-1:0] head_cnt,
  output logic      [SUM_W-1:0] head_sum,
  output logic                  head_ovf
);

  logic [CNT_W-1:0] cnt_q_r [0:1];
  logic [SUM_W-1:0] sum_q_r [0:1];
  logic             ovf_q_r [0:1];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cnt_q_r[wr_ptr_r] <= push_cnt;
      sum_q_r[wr_ptr_r] <= push_sum;
      ovf_q_r[wr_ptr_r] <= push_ovf;
    end
  end

  assign count      = count_r;
  assign head_valid = (count_r != 2'd0);
  assign head_cnt   = cnt_q_r[rd_ptr_r];
  assign head_sum   = sum_q_r[rd_ptr_r];
  assign head_ovf   = ovf_q_r[rd_ptr_r];

endmodule

`default_nettype wire

// File: sv/vln_front.sv
`default_nettype none

module vln_front #(
  parameter int MAX_LEN = 64,
  parameter int CNT_W   = 7,
  parameter int IDX_W   = 6,
  parameter int SUM_W   = 53
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire vln_pkg::in_item_t              in_item,
  input  wire logic [1:0]                     q_count,
  output logic                                q_push,
  output logic      [CNT_W-1:0]               q_cnt,
  output logic      [SUM_W-1:0]               q_sum,
  output logic                                q_ovf,
  output logic                                wr_en,
  output logic      [IDX_W:0]                 wr_addr,
  output logic      [vln_pkg::ELEM_BITS-1:0]  wr_data
);

  localparam int E = vln_pkg::ELEM_BITS;

  logic             accept;
  logic             drop;
  logic [E-1:0]     el;
  logic [E-1:0]     mag;
  logic [SUM_W-1:0] sum_sq;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_last_r, s1_last_nxt;
  logic [CNT_W-1:0] s1_cnt_r, s1_cnt_nxt;
  logic             s1_ovf_r, s1_ovf_nxt;
  logic [2*E-1:0]   sq_r, sq_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // both banks hold closed vectors, or one does and another close is in flight
  assign in_stall = (q_count == 2'd2) || (q_push && (q_count == 2'd1));
  assign accept   = in_valid && !in_stall;
  assign drop     = (cnt_r == CNT_W'(MAX_LEN));
  assign el       = in_item.element;
  assign mag      = el[E-1] ? (~el + E'(1)) : el;
  assign sum_sq   = sum_r + SUM_W'(sq_r);

  always_comb begin
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    bank_nxt     = bank_r;
    s1_valid_nxt = accept;
    s1_last_nxt  = in_item.last;
    s1_cnt_nxt   = drop ? cnt_r : cnt_r + CNT_W'(1);
    s1_ovf_nxt   = ovf_r || drop;
    sq_nxt       = drop ? '0 : ({{E{1'b0}}, mag} * {{E{1'b0}}, mag});
    if (accept) begin
      if (in_item.last) begin
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        bank_nxt = ~bank_r;
      end else begin
        cnt_nxt = s1_cnt_nxt;
        ovf_nxt = s1_ovf_nxt;
      end
    end
    sum_nxt = sum_r;
    if (s1_valid_r) begin
      sum_nxt = s1_last_r ? '0 : sum_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      bank_r     <= 1'b0;
      s1_valid_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      bank_r     <= bank_nxt;
      s1_valid_r <= s1_valid_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= s1_last_nxt;
    s1_cnt_r  <= s1_cnt_nxt;
    s1_ovf_r  <= s1_ovf_nxt;
    sq_r      <= sq_nxt;
  end

  assign q_push  = s1_valid_r && s1_last_r;
  assign q_cnt   = s1_cnt_r;
  assign q_sum   = sum_sq;
  assign q_ovf   = s1_ovf_r;
  assign wr_en   = accept && !drop;
  assign wr_addr = {bank_r, cnt_r[IDX_W-1:0]};
  assign wr_data = el;

endmodule

`default_nettype wire

// File: sv/vln_back.sv
`default_nettype none

module vln_back #(
  parameter int CNT_W  = 7,
  parameter int IDX_W  = 6,
  parameter int SUM_W  = 53,
  parameter int ROOT_W = 27
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire logic [CNT_W-1:0]               q_cnt,
  input  wire logic [SUM_W-1:0]               q_sum,
  input  wire logic                           q_ovf,
  output logic                                q_pop,
  output logic      [IDX_W:0]                 rd_addr,
  input  wire logic [vln_pkg::ELEM_BITS-1:0]  rd_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output vln_pkg::out_item_t                  out_item
);

  localparam int E      = vln_pkg::ELEM_BITS;
  localparam int FO     = vln_pkg::FRAC_OUT;
  localparam int STEP_W = $clog2(ROOT_W);

  vln_pkg::back_state_t state_r, state_nxt;

  logic [ROOT_W+1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [2*ROOT_W-1:0] x_r, x_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                bank_r, bank_nxt;
  logic                neg_r, neg_nxt;
  logic                m0_r, m0_nxt;
  logic [ROOT_W-1:0]   drem_r, drem_nxt;
  logic [FO:0]         quo_r, quo_nxt;
  logic                out_valid_r, out_valid_nxt;
  vln_pkg::out_item_t  out_item_r, out_item_nxt;

  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic                sq_ge;
  logic                dbit;
  logic [ROOT_W:0]     div_sh;
  logic [ROOT_W:0]     div_d;
  logic                dv_ge;
  logic [E-1:0]        mag;
  logic                last_elem;
  logic                load_out;
  logic [vln_pkg::UNIT_W-1:0] uq;

  // square root: one root bit per cycle
  assign rem_sh = {rem_r[ROOT_W-1:0], x_r[2*ROOT_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  // restoring division: one quotient bit per cycle, dividend is magnitude * 2^FO
  assign dbit   = (step_r == STEP_W'(FO)) ? m0_r : 1'b0;
  assign div_sh = {drem_r, dbit};
  assign div_d  = {1'b0, root_r};
  assign dv_ge  = (div_sh >= div_d);

  assign mag       = rd_data[E-1] ? (~rd_data + E'(1)) : rd_data;
  assign last_elem = ((CNT_W'(idx_r) + CNT_W'(1)) == q_cnt);
  assign load_out  = (state_r == vln_pkg::S_EMIT) && (!out_valid_r || !out_stall);
  assign uq        = vln_pkg::UNIT_W'(quo_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vln_pkg::S_IDLE: begin
        if (q_valid) begin
          state_nxt = vln_pkg::S_SQRT;
        end
      end
      vln_pkg::S_SQRT: begin
        if (step_r == '0) begin
          state_nxt = vln_pkg::S_FETCH;
        end
      end
      vln_pkg::S_FETCH: begin
        state_nxt = vln_pkg::S_LOAD;
      end
      vln_pkg::S_LOAD: begin
        state_nxt = (root_r == '0) ? vln_pkg::S_EMIT : vln_pkg::S_DIV;
      end
      vln_pkg::S_DIV: begin
        if (step_r == '0) begin
          state_nxt = vln_pkg::S_EMIT;
        end
      end
      vln_pkg::S_EMIT: begin
        if (load_out) begin
          state_nxt = last_elem ? vln_pkg::S_IDLE : vln_pkg::S_FETCH;
        end
      end
      default: begin
        state_nxt = vln_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    x_nxt         = x_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    bank_nxt      = bank_r;
    neg_nxt       = neg_r;
    m0_nxt        = m0_r;
    drem_nxt      = drem_r;
    quo_nxt       = quo_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    q_pop         = 1'b0;
    case (state_r)
      vln_pkg::S_IDLE: begin
        rem_nxt  = '0;
        root_nxt = '0;
        x_nxt    = (2*ROOT_W)'(q_sum);
        step_nxt = STEP_W'(ROOT_W - 1);
      end
      vln_pkg::S_SQRT: begin
        rem_nxt  = sq_ge ? (rem_sh - trial) : rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], sq_ge};
        x_nxt    = x_r << 2;
        step_nxt = step_r - STEP_W'(1);
      end
      vln_pkg::S_FETCH: begin
      end
      vln_pkg::S_LOAD: begin
        neg_nxt  = rd_data[E-1];
        m0_nxt   = mag[0];
        drem_nxt = ROOT_W'(mag >> 1);
        quo_nxt  = '0;
        step_nxt = STEP_W'(FO);
      end
      vln_pkg::S_DIV: begin
        drem_nxt = dv_ge ? ROOT_W'(div_sh - div_d) : ROOT_W'(div_sh);
        quo_nxt  = {quo_r[FO-1:0], dv_ge};
        step_nxt = step_r - STEP_W'(1);
      end
      vln_pkg::S_EMIT: begin
        if (load_out) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.unit_value    = neg_r ? (~uq + vln_pkg::UNIT_W'(1)) : uq;
          out_item_nxt.norm          = vln_pkg::NORM_W'(root_r);
          out_item_nxt.status        = (root_r == '0) ? vln_pkg::ST_ZERO :
                                       (q_ovf ? vln_pkg::ST_TRUNC : vln_pkg::ST_OK);
          out_item_nxt.end_of_vector = last_elem;
          if (last_elem) begin
            q_pop    = 1'b1;
            idx_nxt  = '0;
            bank_nxt = ~bank_r;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vln_pkg::S_IDLE;
      idx_r       <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    x_r        <= x_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    m0_r       <= m0_nxt;
    drem_r     <= drem_nxt;
    quo_r      <= quo_nxt;
    out_item_r <= out_item_nxt;
  end

  assign rd_addr   = {bank_r, idx_r};
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_queue_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != vln_pkg::S_IDLE) |-> q_valid)
    else $error("descriptor queue empty while a vector is in progress");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vln_pkg::S_SQRT) |-> (rem_r <= {1'b0, root_r, 1'b0}))
    else $error("square root remainder exceeds twice the partial root");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vln_pkg::S_DIV) |-> (drem_r < root_r))
    else $error("division remainder not below the norm");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (quo_r <= {1'b1, {FO{1'b0}}}))
    else $error("unit value magnitude above one");

endmodule

`default_nettype wire

// File: sv/vector_l2_normalize_top.sv
// Throughput: elements load one per cycle while one of the two element banks is free;
//   the back end works on one vector at a time, with a bit-serial square root per vector
//   and a memory read and a bit-serial divider per result.
// Reset: synchronous active-low rst_n clears the counters, queue and FSM; the element
//   memory is not cleared and is only read where written for the current vector.
`default_nettype none

module vector_l2_normalize_top #(
  parameter int MAX_LEN = vln_pkg::MAX_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire vln_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output vln_pkg::out_item_t      out_item
);

  localparam int E      = vln_pkg::ELEM_BITS;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SUM_W  = 2*E - 1 + $clog2(MAX_LEN);
  localparam int ROOT_W = (SUM_W + 1) / 2;

  logic [1:0]       q_count;
  logic             q_push;
  logic [CNT_W-1:0] push_cnt;
  logic [SUM_W-1:0] push_sum;
  logic             push_ovf;
  logic             q_pop;
  logic             q_valid;
  logic [CNT_W-1:0] head_cnt;
  logic [SUM_W-1:0] head_sum;
  logic             head_ovf;
  logic             wr_en;
  logic [IDX_W:0]   wr_addr;
  logic [E-1:0]     wr_data;
  logic [IDX_W:0]   rd_addr;
  logic [E-1:0]     rd_data;

  vln_front #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .IDX_W   (IDX_W),
    .SUM_W   (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_cnt    (push_cnt),
    .q_sum    (push_sum),
    .q_ovf    (push_ovf),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  vln_store #(
    .AW (IDX_W + 1),
    .DW (E)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vln_queue #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cnt   (push_cnt),
    .push_sum   (push_sum),
    .push_ovf   (push_ovf),
    .pop        (q_pop),
    .count      (q_count),
    .head_valid (q_valid),
    .head_cnt   (head_cnt),
    .head_sum   (head_sum),
    .head_ovf   (head_ovf)
  );

  vln_back #(
    .CNT_W  (CNT_W),
    .IDX_W  (IDX_W),
    .SUM_W  (SUM_W),
    .ROOT_W (ROOT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cnt     (head_cnt),
    .q_sum     (head_sum),
    .q_ovf     (head_ovf),
    .q_pop     (q_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VEC_CAP = vln_pkg::MAX_LEN_DEF;

  typedef logic signed [vln_pkg::ELEM_BITS-1:0] elem_t;
  typedef elem_t elem_q_t[$];

  localparam elem_t ELEM_MIN = elem_t'(24'h800000);
  localparam elem_t ELEM_MAX = elem_t'(24'h7fffff);

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  vln_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  vln_pkg::out_item_t out_item;

  // Mirror of the block: elements of the open vector, their sum of squares,
  // and whether any element was dropped for lack of room.
  elem_t       vec_elems[$];
  logic [63:0] sum_sq    = '0;
  logic        truncated = 1'b0;

  vln_pkg::out_item_t expected_units[$];
  int        error_count = 0;
  int        max_gap     = 0;
  int        max_stall   = 0;
  int        stall_left  = 0;

  vector_l2_normalize_top #(
    .MAX_LEN(VEC_CAP)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] abs_elem(input elem_t e);
    longint wide;
    wide = longint'(e);
    return (wide < 0) ? 64'(-wide) : 64'(wide);
  endfunction

  // Bitwise floor square root, most significant root bit first.
  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic void predict_element(input elem_t e, input logic is_last);
    logic [63:0] mag;
    logic [63:0] quot;
    logic [63:0] norm_v;
    logic [vln_pkg::STAT_W-1:0] st;
    vln_pkg::out_item_t res;
    if (vec_elems.size() < VEC_CAP) begin
      mag = abs_elem(e);
      sum_sq += mag * mag;
      vec_elems.push_back(e);
    end else begin
      truncated = 1'b1;
    end
    if (!is_last) return;
    norm_v = floor_root(sum_sq);
    st = (norm_v == 0) ? vln_pkg::ST_ZERO :
         (truncated ? vln_pkg::ST_TRUNC : vln_pkg::ST_OK);
    foreach (vec_elems[i]) begin
      quot = '0;
      if (norm_v != 0) begin
        quot = (abs_elem(vec_elems[i]) << vln_pkg::FRAC_OUT) / norm_v;
        if (vec_elems[i] < 0) quot = -quot;
      end
      res.unit_value    = quot[vln_pkg::UNIT_W-1:0];
      res.norm          = norm_v[vln_pkg::NORM_W-1:0];
      res.status        = st;
      res.end_of_vector = (i == vec_elems.size() - 1);
      expected_units.push_back(res);
    end
    vec_elems.delete();
    sum_sq    = '0;
    truncated = 1'b0;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
      error_count++;
    end
  endfunction

  // Check each result transaction and draw the stall before the next one.
  always @(posedge clk) begin : result_monitor
    vln_pkg::out_item_t want;
    int k;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
        error_count++;
      end else begin
        want = expected_units.pop_front();
        compare_field("unit_value", 32'(want.unit_value), 32'(out_item.unit_value));
        compare_field("norm", 32'(want.norm), 32'(out_item.norm));
        compare_field("status", 32'(want.status), 32'(out_item.status));
        compare_field("end_of_vector", 32'(want.end_of_vector),
                      32'(out_item.end_of_vector));
      end
      k = $urandom_range(0, max_stall);
      stall_left <= k;
      out_stall  <= (k != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  task automatic send_element(input elem_t e, input logic is_last);
    int gap;
    vln_pkg::in_item_t item;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.element = e;
    item.last    = is_last;
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_element(e, is_last);
  endtask

  task automatic send_vector(input elem_q_t v);
    foreach (v[i]) send_element(v[i], i == v.size() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
  endtask

  function automatic elem_t random_element(input bit small_range);
    logic [31:0] raw;
    elem_t mag;
    raw = $urandom;
    if (small_range) begin
      mag = elem_t'($urandom_range(0, 300));
      return raw[0] ? -mag : mag;
    end
    case ($urandom_range(0, 7))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      default: return raw[vln_pkg::ELEM_BITS-1:0];
    endcase
  endfunction

  task automatic test_extremes();
    elem_q_t v;
    max_gap   = 0;
    max_stall = 0;
    v = {ELEM_MIN};
    send_vector(v);
    v = {ELEM_MAX};
    send_vector(v);
    v = {elem_t'(1)};
    send_vector(v);
    v = {elem_t'(-1)};
    send_vector(v);
    v = {ELEM_MAX, ELEM_MIN, elem_t'(0), elem_t'(1), elem_t'(-1)};
    send_vector(v);
    drain_results();
  endtask

  task automatic test_zero_vector();
    elem_q_t v;
    max_gap   = 4;
    max_stall = 4;
    v = {elem_t'(0)};
    send_vector(v);
    v = {elem_t'(0), elem_t'(0), elem_t'(0)};
    send_vector(v);
    drain_results();
  endtask

  // Quotients that are not exact: negative ones must truncate toward zero.
  task automatic test_truncation();
    elem_q_t v;
    max_gap   = 2;
    max_stall = 4;
    v = {elem_t'(3), elem_t'(4)};
    send_vector(v);
    v = {elem_t'(-3), elem_t'(4)};
    send_vector(v);
    v = {elem_t'(-1), elem_t'(-1), elem_t'(-1)};
    send_vector(v);
    v = {elem_t'(-5), elem_t'(12), elem_t'(0)};
    send_vector(v);
    drain_results();
  endtask

  task automatic test_too_long();
    elem_q_t v;
    max_gap   = 1;
    max_stall = 2;
    // store fills exactly, then the last element itself is dropped
    v.delete();
    repeat (VEC_CAP + 1) v.push_back(random_element(1'b0));
    send_vector(v);
    // overfull with only zeros stored: zero status wins
    v.delete();
    repeat (VEC_CAP) v.push_back('0);
    v.push_back(elem_t'(5));
    send_vector(v);
    drain_results();
  endtask

  task automatic test_random();
    elem_q_t v;
    int sent;
    int len;
    int style;
    sent = 0;
    while (sent < 20) begin
      max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 4;
      max_stall = ($urandom_range(0, 3) == 0) ? 0 : 4;
      len = $urandom_range(1, 8);
      style = $urandom_range(0, 9);
      v.delete();
      repeat (len) v.push_back((style == 0) ? elem_t'(0) : random_element(style == 1));
      send_vector(v);
      sent += len;
    end
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_zero_vector();
    test_truncation();
    test_too_long();
    test_random();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
